// ===== rtl/core/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
`timescale 1ns / 1ps

package ffsa_pkg;

  localparam int unsigned MAX_HOLES_DEF = 64;
  localparam logic [31:0] MEM_SIZE_RESET = 32'hC000_0000;

  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_MEMORY_SIZE = 2'd0;

  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } hole_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_req;
    logic rel_ok;
    logic rel_full;
    logic rd;
    logic cmp_hit;
    logic cmp_miss;
    logic tail_hit;
    logic tail_miss;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic table_full;
    logic mem_empty;
    logic mem_hit;
    logic last_entry;
    logic tail_hit;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/ffsa_datapath.sv =====
// Hole table memory, tail hole, scan index and result registers.
`timescale 1ns / 1ps

module ffsa_datapath #(
  parameter int unsigned MaxHoles = ffsa_pkg::MAX_HOLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffsa_pkg::dp_cmd_t cmd_i,
  output ffsa_pkg::dp_stat_t stat_o,
  input  logic [31:0]       segment_size_i,
  input  logic [31:0]       release_base_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic [31:0]       memory_size_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [31:0]       segment_base_o
);

  localparam int unsigned AW = $clog2(MaxHoles);
  localparam logic [AW:0] DEPTH = (AW + 1)'(MaxHoles);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MaxHoles - 1);

  // Released holes live in a circular buffer ahead of the tail hole, which
  // always holds the oldest (initial) hole.
  ffsa_pkg::hole_t mem_q [MaxHoles];
  ffsa_pkg::hole_t rdata_q;
  ffsa_pkg::hole_t tail_q;
  ffsa_pkg::hole_t wdata;

  logic [AW-1:0] head_q, mem_count_q, idx_q, addr_q;
  logic [AW-1:0] head_dec, rd_addr, waddr;
  logic [AW:0]   addr_sum, addr_wrap;
  logic          we;

  logic [31:0]   size_q, mem_size_q;
  ffsa_pkg::status_e res_status_q, out_status_q;
  logic [31:0]   res_base_q, out_base_q;
  logic          out_valid_q;

  assign addr_sum  = {1'b0, head_q} + {1'b0, idx_q};
  assign addr_wrap = addr_sum - DEPTH;
  assign rd_addr   = (addr_sum >= DEPTH) ? addr_wrap[AW-1:0] : addr_sum[AW-1:0];
  assign head_dec  = (head_q == '0) ? LAST_ADDR : head_q - 1'b1;

  assign we    = cmd_i.rel_ok | cmd_i.cmp_hit;
  assign waddr = cmd_i.rel_ok ? head_dec : addr_q;
  always_comb begin
    if (cmd_i.rel_ok) begin
      wdata.start = release_base_i;
      wdata.size  = segment_size_i;
    end else begin
      wdata.start = rdata_q.start + size_q;
      wdata.size  = rdata_q.size - size_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
      addr_q  <= rd_addr;
    end
  end

  assign stat_o.table_full = (mem_count_q == LAST_ADDR);
  assign stat_o.mem_empty  = (mem_count_q == '0);
  assign stat_o.mem_hit    = (rdata_q.size >= size_q);
  assign stat_o.last_entry = (idx_q == mem_count_q - 1'b1);
  assign stat_o.tail_hit   = (tail_q.size >= size_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q  <= ffsa_pkg::MEM_SIZE_RESET;
      tail_q      <= '{start: 32'd0, size: ffsa_pkg::MEM_SIZE_RESET};
      head_q      <= '0;
      mem_count_q <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // reinitialize to a single hole of the new size
        mem_size_q  <= cfg_wdata_i;
        tail_q      <= '{start: 32'd0, size: cfg_wdata_i};
        head_q      <= '0;
        mem_count_q <= '0;
      end
      if (cmd_i.rel_ok) begin
        head_q      <= head_dec;
        mem_count_q <= mem_count_q + 1'b1;
      end
      if (cmd_i.tail_hit) begin
        tail_q.start <= tail_q.start + size_q;
        tail_q.size  <= tail_q.size - size_q;
      end
      if (cmd_i.latch_req) begin
        idx_q <= '0;
      end else if (cmd_i.cmp_miss) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      size_q <= segment_size_i;
    end
    if (cmd_i.rel_ok) begin
      res_status_q <= ffsa_pkg::ST_OK;
      res_base_q   <= 32'd0;
    end else if (cmd_i.rel_full) begin
      res_status_q <= ffsa_pkg::ST_FULL;
      res_base_q   <= 32'd0;
    end else if (cmd_i.cmp_hit) begin
      res_status_q <= ffsa_pkg::ST_OK;
      res_base_q   <= rdata_q.start;
    end else if (cmd_i.tail_hit) begin
      res_status_q <= ffsa_pkg::ST_OK;
      res_base_q   <= tail_q.start;
    end else if (cmd_i.tail_miss) begin
      res_status_q <= ffsa_pkg::ST_NO_SPACE;
      res_base_q   <= 32'd0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_base_q   <= res_base_q;
    end
  end

  assign memory_size_o  = mem_size_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign segment_base_o = out_base_q;

  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rel_full && !cfg_we_i) |=> $stable(mem_count_q))
    else $error("dropped release changed the hole count");

  a_release_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rel_ok && !cfg_we_i) |=> (mem_count_q == $past(mem_count_q) + 1'b1))
    else $error("release did not add one hole");

  a_hit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp_hit |-> (rdata_q.size >= size_q))
    else $error("segment taken from a hole that is too small");

endmodule

// ===== rtl/core/ffsa_ctrl.sv =====
// Request sequencer for the hole table scan.
`timescale 1ns / 1ps

module ffsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  ffsa_pkg::dp_stat_t stat_i,
  output ffsa_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CMP  = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          if (command_i == ffsa_pkg::CMD_RELEASE) begin
            cmd_o.rel_ok   = !stat_i.table_full;
            cmd_o.rel_full = stat_i.table_full;
            state_d        = S_DONE;
          end else if (stat_i.mem_empty) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (stat_i.mem_hit) begin
          cmd_o.cmp_hit = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.cmp_miss = 1'b1;
          state_d        = stat_i.last_entry ? S_TAIL : S_READ;
        end
      end
      S_TAIL: begin
        cmd_o.tail_hit  = stat_i.tail_hit;
        cmd_o.tail_miss = !stat_i.tail_hit;
        state_d         = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: config port and wiring.
//
// Usage: requests enter on the input channel (in_valid_i / in_stall_o) with
// command_i (allocate or release), segment_size_i and release_base_i. Every
// request yields exactly one result on the output channel (out_valid_o /
// out_stall_i) carrying status_o and segment_base_o.
// The block handles one request at a time. A release is accepted and then
// loads its result into the output register. An allocate visits the released
// holes in order, newest first, with one registered read of the hole memory
// and one compare per visit; when all released holes miss, the oldest hole is
// tried last. The result shows in the cycle after the output register is
// loaded, and the next request is accepted once the block is back in idle.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and scanned, and waits for the register to free.
// Reset leaves one hole of memory_size bytes at offset 0 (3 GiB by default);
// no clearing pass is needed. Writing memory_size over the APB port (only
// while idle) reinitializes the table the same way.
`timescale 1ns / 1ps

module first_fit_segment_allocator #(
  parameter int unsigned MaxHoles = ffsa_pkg::MAX_HOLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffsa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [31:0]                  segment_size_i,
  input  logic [31:0]                  release_base_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [31:0]                  segment_base_o
);

  ffsa_pkg::dp_cmd_t  cmd;
  ffsa_pkg::dp_stat_t stat;
  logic               cfg_we;
  logic [31:0]        memory_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ffsa_pkg::REG_MEMORY_SIZE);
  assign prdata = (paddr == ffsa_pkg::REG_MEMORY_SIZE) ? memory_size : 32'd0;

  ffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffsa_datapath #(
    .MaxHoles (MaxHoles)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .segment_size_i (segment_size_i),
    .release_base_i (release_base_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata),
    .memory_size_o  (memory_size),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .segment_base_o (segment_base_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the first-fit segment allocator.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned HOLES = ffsa_pkg::MAX_HOLES_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [ffsa_pkg::PADDR_W-1:0] UNMAPPED_ADDR = 2'd2;

  typedef struct {
    logic        cmd;
    logic [31:0] size;
    logic [31:0] base;
  } seg_req_t;

  typedef struct {
    ffsa_pkg::status_e status;
    logic [31:0]       base;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ffsa_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = ffsa_pkg::CMD_ALLOCATE;
  logic [31:0] segment_size_i = '0;
  logic [31:0] release_base_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] segment_base_o;

  // Predicted hole table
  logic [31:0] free_start [HOLES];
  logic [31:0] free_size [HOLES];
  int unsigned free_count;
  logic [31:0] mem_size_model;

  seg_req_t req_backlog [$];
  grant_t   grants_due [$];
  seg_req_t next_req;
  grant_t   predicted;
  grant_t   oldest;
  int       outstanding = 0;
  int       errors = 0;
  int       send_gap_pct = 31;
  int       recv_gap_pct = 56;
  logic     pressure_arm = 1'b0;
  logic     hold_out = 1'b0;

  first_fit_segment_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .segment_size_i(segment_size_i),
    .release_base_i(release_base_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .segment_base_o(segment_base_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void reset_holes(input logic [31:0] mem);
    mem_size_model = mem;
    for (int i = 0; i < HOLES; i++) begin
      free_start[i] = '0;
      free_size[i] = '0;
    end
    free_size[0] = mem;
    free_count = 1;
  endfunction

  // Apply one request to the predicted table and return the grant it yields.
  function automatic grant_t first_fit_grant(input seg_req_t r);
    grant_t g;
    g.status = ffsa_pkg::ST_NO_SPACE;
    g.base = '0;
    if (r.cmd == ffsa_pkg::CMD_ALLOCATE) begin
      for (int i = 0; i < free_count; i++) begin
        if (free_size[i] >= r.size) begin
          g.status = ffsa_pkg::ST_OK;
          g.base = free_start[i];
          free_start[i] = free_start[i] + r.size;
          free_size[i] = free_size[i] - r.size;
          break;
        end
      end
    end else if (free_count >= HOLES) begin
      g.status = ffsa_pkg::ST_FULL;
    end else begin
      for (int i = free_count; i > 0; i--) begin
        free_start[i] = free_start[i-1];
        free_size[i] = free_size[i-1];
      end
      free_start[0] = r.base;
      free_size[0] = r.size;
      free_count++;
      g.status = ffsa_pkg::ST_OK;
    end
    return g;
  endfunction

  function automatic logic [31:0] pick_size(input logic [31:0] mem);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return $urandom;
    if (r < 24) return $urandom_range(mem, 0);
    if (r < 55) return $urandom_range(64, 1);
    return $urandom_range(mem / 4, 0);
  endfunction

  function automatic logic [31:0] pick_base();
    if ($urandom_range(0, 1) != 0) return $urandom;
    return $urandom_range(32'h0001_0000, 0);
  endfunction

  task automatic push_req(input logic cmd, input logic [31:0] size, input logic [31:0] base);
    seg_req_t r;
    r.cmd = cmd;
    r.size = size;
    r.base = base;
    req_backlog.push_back(r);
    outstanding++;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB transfer; a read is checked against the predicted register value.
  task automatic csr_cycle(input logic wr, input logic [ffsa_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (!wr && prdata !== mem_size_model) begin
      $display("%0t: memory_size readback expected %h actual %h", $time, mem_size_model, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_memory_size(input logic [31:0] mem);
    csr_cycle(1'b1, ffsa_pkg::REG_MEMORY_SIZE, mem);
    reset_holes(mem);
    csr_cycle(1'b0, ffsa_pkg::REG_MEMORY_SIZE, '0);
  endtask

  // Request driver: predict on acceptance, then offer the next request or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        next_req.cmd = command_i;
        next_req.size = segment_size_i;
        next_req.base = release_base_i;
        predicted = first_fit_grant(next_req);
        grants_due.push_back(predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          next_req = req_backlog.pop_front();
          in_valid_i <= 1'b1;
          command_i <= next_req.cmd;
          segment_size_i <= next_req.size;
          release_base_i <= next_req.base;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result status %0d base %h", $time, status_o, segment_base_o);
        errors++;
      end else begin
        oldest = grants_due.pop_front();
        outstanding--;
        if (status_o !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, status_o);
          errors++;
        end
        if (segment_base_o !== oldest.base) begin
          $display("%0t: segment_base expected %h actual %h", $time, oldest.base,
                   segment_base_o);
          errors++;
        end
      end
    end
    out_stall_i <= hold_out || ($urandom_range(0, 99) < recv_gap_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (pressure_arm);
    @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] phase_mem [9];
    int          rel_pct [9];
    phase_mem = '{32'hFFFF_FFFF, 32'h0000_1000, 32'h0, 32'h0000_0001, 32'hC000_0000,
                  32'h0, 32'h0010_0000, 32'hFFFF_FFFF, 32'h0};
    rel_pct = '{40, 95, 50, 30, 60, 90, 45, 50, 35};
    reset_holes(ffsa_pkg::MEM_SIZE_RESET);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset value, zero-size grant, exact fit, emptied hole kept, wraparound.
    csr_cycle(1'b0, ffsa_pkg::REG_MEMORY_SIZE, '0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h0, 32'hFFFF_FFFF);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h0000_1000, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'hFFFF_FFFF, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'hBFFF_F000, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h1, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h0, 32'h0);
    push_req(ffsa_pkg::CMD_RELEASE, 32'h0000_0100, 32'hFFFF_FFF0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h20, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'hE0, 32'h0);
    push_req(ffsa_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(ffsa_pkg::CMD_RELEASE, 32'h10, 32'h1234_5678);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h11, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h10, 32'h0);
    push_req(ffsa_pkg::CMD_RELEASE, 32'h0, 32'h0);
    wait_drained();

    // Empty memory: only zero-size allocations fit until something is released.
    set_memory_size(32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h0, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h1, 32'h0);
    push_req(ffsa_pkg::CMD_RELEASE, 32'h40, 32'h100);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h40, 32'h0);
    wait_drained();

    // Write to an unmapped address must leave the table alone.
    csr_cycle(1'b1, UNMAPPED_ADDR, 32'h0000_1234);
    csr_cycle(1'b0, ffsa_pkg::REG_MEMORY_SIZE, '0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h20, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h0, 32'h0);
    wait_drained();

    set_memory_size(32'h1);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h2, 32'h0);
    push_req(ffsa_pkg::CMD_ALLOCATE, 32'h1, 32'h0);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_gap_pct = 56;
        recv_gap_pct = 31;
      end
      if (p == 6) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      set_memory_size(phase_mem[p] != 0 ? phase_mem[p] : $urandom);
      if (p == 6) pressure_arm = 1'b1;
      for (int n = 0; n < 62; n++) begin
        if ($urandom_range(0, 99) < rel_pct[p]) begin
          push_req(ffsa_pkg::CMD_RELEASE, pick_size(mem_size_model), pick_base());
        end else begin
          push_req(ffsa_pkg::CMD_ALLOCATE, pick_size(mem_size_model), $urandom);
        end
      end
      wait_drained();
    end

    repeat (2 * HOLES + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== first_fit_segment_allocator.f =====
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_datapath.sv
rtl/core/ffsa_ctrl.sv
rtl/core/first_fit_segment_allocator.sv
tb/sv/testbench.sv
